FILE: rtl/kre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key report events package
// Beat types for the request and response channels, the per-slot lane result
// and the constants shared by the key report event unit.
// ----------------------------------------------------------------------------
package kre_pkg;

   // Number of key code fields carried by one boot report.
   localparam int KEY_INPUTS = 6;
   // Width of one key code and of the modifier byte.
   localparam int KEY_W = 8;
   // Shortest report length in bytes that is acted upon.
   localparam logic [6:0] MIN_REPORT_BYTES = 7'd8;

   // Event kind codes.
   localparam logic EVT_PRESS   = 1'b0;
   localparam logic EVT_RELEASE = 1'b1;

   // One request beat: a boot keyboard report.
   typedef struct packed {
      logic [6:0]       report_length;
      logic [KEY_W-1:0] modifier_bits;
      logic [KEY_W-1:0] key_0;
      logic [KEY_W-1:0] key_1;
      logic [KEY_W-1:0] key_2;
      logic [KEY_W-1:0] key_3;
      logic [KEY_W-1:0] key_4;
      logic [KEY_W-1:0] key_5;
   } req_type;

   // One response beat: a single key event.
   typedef struct packed {
      logic             is_release;
      logic [KEY_W-1:0] event_modifier;
      logic [KEY_W-1:0] event_key;
      logic             last_event;
   } rsp_type;

   // What one lane found for its slot.
   typedef struct packed {
      logic rel_hit;
      logic press_hit;
   } lane_flags_type;

endpackage

FILE: rtl/kre_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key report events lane
// Checks one key slot: whether its old code was released and whether its new
// code is a fresh press, by comparing against every slot of the other list.
// ----------------------------------------------------------------------------
module kre_lane #(
   parameter int KEY_SLOTS = 6,
   parameter int KEY_FLOOR = 3
) (
   input  logic [7:0]                old_key,
   input  logic [7:0]                new_key,
   input  logic [7:0]                old_keys [KEY_SLOTS],
   input  logic [7:0]                new_keys [KEY_SLOTS],
   output kre_pkg::lane_flags_type   flags
);
   import kre_pkg::*;

   localparam logic [KEY_W-1:0] FLOOR = KEY_W'(KEY_FLOOR);

   logic old_seen;
   logic new_seen;

   // Membership tests against the other report, one comparator per slot.
   always_comb begin
      old_seen = 1'b0;
      new_seen = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if (new_keys[j] == old_key) begin
            old_seen = 1'b1;
         end
         if (old_keys[j] == new_key) begin
            new_seen = 1'b1;
         end
      end
   end

   // A real key code that vanished is a release; one that appeared is a press.
   assign flags.rel_hit   = (old_key > FLOOR) && !old_seen;
   assign flags.press_hit = (new_key > FLOOR) && !new_seen;

endmodule

FILE: rtl/kre_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key report events emitter
// Holds the pending event flags of one report and sends them out one beat per
// cycle while rsp_ready allows, lowest slot first and release before press,
// through an output register.
// ----------------------------------------------------------------------------
module kre_emit #(
   parameter int KEY_SLOTS = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [2*KEY_SLOTS-1:0]   load_flags,
   input  logic [7:0]               load_old [KEY_SLOTS],
   input  logic [7:0]               load_new [KEY_SLOTS],
   input  logic [7:0]               load_mod,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output kre_pkg::rsp_type         rsp_payload
);
   import kre_pkg::*;

   localparam int FW = 2 * KEY_SLOTS;

   logic [FW-1:0]    pend_ff, pend_in;
   logic [KEY_W-1:0] old_ff [KEY_SLOTS];
   logic [KEY_W-1:0] new_ff [KEY_SLOTS];
   logic [KEY_W-1:0] mod_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_payload_ff, rsp_payload_in;

   logic [FW-1:0]    pick;
   logic [FW-1:0]    rest;
   logic             adv;
   logic             sel_rel;
   logic [KEY_W-1:0] sel_key;

   // Isolate the lowest pending flag; the remainder decides the last beat.
   assign pick = pend_ff & (~pend_ff + FW'(1));
   assign rest = pend_ff & ~pick;
   assign adv  = (pend_ff != '0) && (!rsp_valid_ff || rsp_ready);

   // A new report may enter once the current one has handed over its last beat.
   assign can_load = (pend_ff == '0) || (adv && (rest == '0));

   // One-hot selection of the event's key code and kind.
   always_comb begin
      sel_rel = 1'b0;
      sel_key = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         sel_rel = sel_rel | pick[2*i];
         sel_key = sel_key | ({KEY_W{pick[2*i]}} & old_ff[i])
                           | ({KEY_W{pick[2*i+1]}} & new_ff[i]);
      end
   end

   // Next values of the pending flags and the output register.
   always_comb begin
      pend_in = pend_ff;
      if (load) begin
         pend_in = load_flags;
      end else if (adv) begin
         pend_in = rest;
      end

      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_payload_in.is_release     = sel_rel ? EVT_RELEASE : EVT_PRESS;
      rsp_payload_in.event_modifier = sel_rel ? '0 : mod_ff;
      rsp_payload_in.event_key      = sel_key;
      rsp_payload_in.last_event     = (rest == '0);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Report payload held while its events drain.
   always_ff @(posedge clock) begin
      if (load) begin
         old_ff <= load_old;
         new_ff <= load_new;
         mod_ff <= load_mod;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: rtl/keyboard_report_key_events_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard report key events unit
// Turns boot-protocol keyboard reports into a stream of key press and key
// release events by comparing each report with the previous one.
// ----------------------------------------------------------------------------
// When a report is taken, KEY_SLOTS comparison lanes check every slot
// against the stored keys at once, the stored keys are replaced in that same
// cycle, and the events found are queued in the emitter, which sends one
// event beat per cycle while rsp_ready allows; a report gives at most twice
// KEY_SLOTS events. The next report is accepted in the cycle that the
// previous report's last event moves into the output register, and that
// register lets a report be taken while an event still waits for rsp_ready.
// Reports shorter than eight bytes are accepted and dropped without touching
// the stored keys. Slots beyond the six key fields of a report read as key
// code zero.
// ----------------------------------------------------------------------------
module keyboard_report_key_events_unit #(
   parameter int KEY_SLOTS = 6,
   parameter int KEY_FLOOR = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kre_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kre_pkg::rsp_type  rsp_payload
);
   import kre_pkg::*;

   logic [KEY_W-1:0] held_keys_ff [KEY_SLOTS];
   logic [KEY_W-1:0] held_keys_in [KEY_SLOTS];
   logic [KEY_W-1:0] req_keys     [KEY_INPUTS];
   logic [KEY_W-1:0] fresh        [KEY_SLOTS];
   lane_flags_type   lane_flags   [KEY_SLOTS];
   logic [2*KEY_SLOTS-1:0] flags;
   logic             req_fire;
   logic             take;
   logic             can_load;

   // Key fields of the request beat in slot order.
   assign req_keys[0] = req_payload.key_0;
   assign req_keys[1] = req_payload.key_1;
   assign req_keys[2] = req_payload.key_2;
   assign req_keys[3] = req_payload.key_3;
   assign req_keys[4] = req_payload.key_4;
   assign req_keys[5] = req_payload.key_5;

   // One comparison lane per slot; release flag below press flag.
   for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
      if (i < KEY_INPUTS) begin : g_key
         assign fresh[i] = req_keys[i];
      end else begin : g_pad
         assign fresh[i] = '0;
      end

      kre_lane #(
         .KEY_SLOTS (KEY_SLOTS),
         .KEY_FLOOR (KEY_FLOOR)
      ) u_lane (
         .old_key  (held_keys_ff[i]),
         .new_key  (fresh[i]),
         .old_keys (held_keys_ff),
         .new_keys (fresh),
         .flags    (lane_flags[i])
      );

      assign flags[2*i]   = lane_flags[i].rel_hit;
      assign flags[2*i+1] = lane_flags[i].press_hit;
   end

   // Accept handshake; only full-length reports are acted upon.
   assign req_ready = can_load;
   assign req_fire  = req_valid && req_ready;
   assign take      = req_fire && (req_payload.report_length >= MIN_REPORT_BYTES);

   // Stored keys follow every report that is acted upon.
   always_comb begin
      held_keys_in = held_keys_ff;
      if (take) begin
         held_keys_in = fresh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_SLOTS; i++) begin
            held_keys_ff[i] <= '0;
         end
      end else begin
         held_keys_ff <= held_keys_in;
      end
   end

   // Merging stage: queue the lane results and send them one event a beat.
   kre_emit #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (take),
      .load_flags  (flags),
      .load_old    (held_keys_ff),
      .load_new    (fresh),
      .load_mod    (req_payload.modifier_bits),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: bench/keyboard_report_key_events_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard report key events unit testbench
// Feeds boot keyboard reports through the request channel and checks every
// key event beat on the response channel, in order, against events derived
// here from the same reports and a local copy of the held keys. Directed
// reports cover the edge cases first. Random typing sequences follow, with
// random idling on both sides, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module keyboard_report_key_events_unit_tb;
   import kre_pkg::*;

   localparam int KEY_SLOTS   = 6;
   localparam int KEY_FLOOR   = 3;
   localparam int IDLE_PCT    = 38;
   localparam int HOLD_CYCLES = 200;
   localparam int LIMIT       = 400000;
   localparam int SHOWN_MAX   = 10;

   typedef logic [KEY_W-1:0] key_row_type [KEY_SLOTS];

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Reports waiting to be offered, and key events still to arrive.
   req_type  report_queue[$];
   rsp_type  key_events[$];
   // Keys held after the last accepted report, as the block should see them.
   key_row_type held_keys    = '{default: '0};
   // Keys of the last generated report, used to build typing sequences.
   key_row_type typed_keys   = '{default: '0};

   bit steady     = 1'b0;
   bit hold_armed = 1'b0;
   bit hold_done  = 1'b0;
   int hold_left  = 0;

   int reports_taken = 0;
   int short_reports = 0;
   int events_seen   = 0;
   int presses_seen  = 0;
   int releases_seen = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   keyboard_report_key_events_unit #(
      .KEY_SLOTS(KEY_SLOTS),
      .KEY_FLOOR(KEY_FLOOR)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // Clock and the single reset pulse.
   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("Timeout after %0d cycles, %0d key events outstanding.",
                  cycle_count, key_events.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_type make_report(int len, logic [7:0] mods,
                                           key_row_type keys);
      req_type r;
      r.report_length = len[6:0];
      r.modifier_bits = mods;
      r.key_0 = keys[0];
      r.key_1 = keys[1];
      r.key_2 = keys[2];
      r.key_3 = keys[3];
      r.key_4 = keys[4];
      r.key_5 = keys[5];
      return r;
   endfunction

   function automatic bit key_listed(key_row_type row, logic [KEY_W-1:0] code);
      foreach (row[i]) begin
         if (row[i] == code) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the events one accepted report causes and queues them.
   function automatic void derive_key_events(req_type r);
      key_row_type fresh;
      rsp_type  ev;
      int       found;
      found = 0;
      if (r.report_length < MIN_REPORT_BYTES) begin
         short_reports++;
         return;
      end
      fresh = '{r.key_0, r.key_1, r.key_2, r.key_3, r.key_4, r.key_5};
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (held_keys[i] > KEY_FLOOR && !key_listed(fresh, held_keys[i])) begin
            ev = '{is_release: EVT_RELEASE, event_modifier: '0,
                   event_key: held_keys[i], last_event: 1'b0};
            key_events.push_back(ev);
            found++;
         end
         if (fresh[i] > KEY_FLOOR && !key_listed(held_keys, fresh[i])) begin
            ev = '{is_release: EVT_PRESS, event_modifier: r.modifier_bits,
                   event_key: fresh[i], last_event: 1'b0};
            key_events.push_back(ev);
            found++;
         end
      end
      if (found > 0) key_events[key_events.size() - 1].last_event = 1'b1;
      held_keys = fresh;
   endfunction

   // Mostly codes from a small pool so that keys overlap between reports.
   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 15) return KEY_W'($urandom_range(KEY_FLOOR));
      if (roll < 75) return KEY_W'($urandom_range(KEY_FLOOR + 12, KEY_FLOOR + 1));
      return KEY_W'($urandom_range(255));
   endfunction

   // Random report: mostly a small change to the keys typed last, some fully
   // random reports and some short reports that the block must drop.
   function automatic req_type random_report();
      key_row_type keys;
      int unsigned kind;
      int unsigned slot_a;
      int unsigned slot_b;
      logic [KEY_W-1:0] spare;
      int          len;
      kind = $urandom_range(99);
      if (kind < 10) begin
         foreach (keys[i]) keys[i] = KEY_W'($urandom_range(255));
         return make_report($urandom_range(7), KEY_W'($urandom_range(255)), keys);
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 8) : 8;
      if (kind < 25) begin
         foreach (keys[i]) keys[i] = pick_key();
      end else begin
         keys = typed_keys;
         repeat ($urandom_range(2, 1)) begin
            slot_a = $urandom_range(KEY_SLOTS - 1);
            keys[slot_a] = ($urandom_range(2) == 0) ? '0 : pick_key();
         end
         if ($urandom_range(4) == 0) begin
            slot_a = $urandom_range(KEY_SLOTS - 1);
            slot_b = $urandom_range(KEY_SLOTS - 1);
            spare        = keys[slot_a];
            keys[slot_a] = keys[slot_b];
            keys[slot_b] = spare;
         end
      end
      typed_keys = keys;
      return make_report(len, KEY_W'($urandom_range(255)), keys);
   endfunction

   // Request driver: offers the next report unless it idles this cycle.
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            derive_key_events(req_payload);
            reports_taken++;
         end
         if (!req_valid || req_ready) begin
            if (report_queue.size() > 0 &&
                (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid   <= 1'b1;
               req_payload <= report_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // A single long receiver hold-off, counted down once it has been armed.
   always @(posedge clock) begin : hold_off
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end
   end

   // Response monitor: checks each event beat, then decides rsp_ready.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            events_seen++;
            if (rsp_payload.is_release == EVT_RELEASE) releases_seen++;
            else presses_seen++;
            if (key_events.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_MAX)
                  $display("Unexpected key event: release=%0b mod=%02h key=%02h last=%0b",
                           rsp_payload.is_release, rsp_payload.event_modifier,
                           rsp_payload.event_key, rsp_payload.last_event);
            end else begin
               want = key_events.pop_front();
               if (rsp_payload.is_release     !== want.is_release     ||
                   rsp_payload.event_modifier !== want.event_modifier ||
                   rsp_payload.event_key      !== want.event_key      ||
                   rsp_payload.last_event     !== want.last_event) begin
                  mismatches++;
                  if (mismatches <= SHOWN_MAX) begin
                     $display("Key event %0d: expected release=%0b mod=%02h key=%02h last=%0b",
                              events_seen, want.is_release, want.event_modifier,
                              want.event_key, want.last_event);
                     $display("   got release=%0b mod=%02h key=%02h last=%0b",
                              rsp_payload.is_release, rsp_payload.event_modifier,
                              rsp_payload.event_key, rsp_payload.last_event);
                  end
               end
            end
         end
         // The long hold-off lets the block fill up and stall its input.
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Waits until every report is taken and every expected event has come.
   task automatic wait_for_drain();
      @(negedge clock);
      while (report_queue.size() != 0 || req_valid || key_events.size() != 0)
         @(negedge clock);
   endtask

   // Stimulus: directed reports, then two random batches.
   initial begin : stimulus
      // Directed reports covering the corner cases.
      report_queue.push_back(make_report(8, 8'h00, '{8'h00, 8'h00, 8'h00,
                                                     8'h00, 8'h00, 8'h00}));
      report_queue.push_back(make_report(8, 8'hFF, '{8'h04, 8'h05, 8'h06,
                                                     8'h00, 8'h00, 8'h00}));
      // Same keys reordered: no event.
      report_queue.push_back(make_report(8, 8'h01, '{8'h06, 8'h04, 8'h05,
                                                     8'h00, 8'h00, 8'h00}));
      // Short reports are dropped.
      report_queue.push_back(make_report(7, 8'hFF, '{8'hFF, 8'hFF, 8'hFF,
                                                     8'hFF, 8'hFF, 8'hFF}));
      report_queue.push_back(make_report(0, 8'h00, '{8'h00, 8'h00, 8'h00,
                                                     8'h00, 8'h00, 8'h00}));
      report_queue.push_back(make_report(8, 8'h00, '{8'h00, 8'h00, 8'h00,
                                                     8'h00, 8'h00, 8'h00}));
      // Same code in every slot, longest report.
      report_queue.push_back(make_report(64, 8'h80, '{8'hFF, 8'hFF, 8'hFF,
                                                      8'hFF, 8'hFF, 8'hFF}));
      // Every slot both releases and presses.
      report_queue.push_back(make_report(9, 8'h55, '{8'hFE, 8'hFD, 8'hFC,
                                                     8'hFB, 8'hFA, 8'hF9}));
      // Codes at and below the floor never give events.
      report_queue.push_back(make_report(8, 8'hAA, '{8'h01, 8'h02, 8'h03,
                                                     8'h04, 8'h00, 8'h00}));
      report_queue.push_back(make_report(8, 8'h0F, '{8'h03, 8'h03, 8'h04,
                                                     8'h04, 8'h05, 8'h05}));
      report_queue.push_back(make_report(8, 8'hF0, '{8'h80, 8'h7F, 8'h40,
                                                     8'h20, 8'h10, 8'h08}));
      report_queue.push_back(make_report(63, 8'h00, '{8'h80, 8'h7F, 8'h40,
                                                      8'h20, 8'h10, 8'h08}));
      report_queue.push_back(make_report(8, 8'h3C, '{8'h00, 8'h00, 8'h00,
                                                     8'h00, 8'h00, 8'hE0}));
      report_queue.push_back(make_report(8, 8'h00, '{8'h00, 8'h00, 8'h00,
                                                     8'h00, 8'h00, 8'h00}));
      report_queue.push_back(make_report(7, 8'h00, '{8'h04, 8'h04, 8'h04,
                                                     8'h04, 8'h04, 8'h04}));
      report_queue.push_back(make_report(8, 8'h00, '{8'h00, 8'h00, 8'h00,
                                                     8'h00, 8'h00, 8'h00}));
      wait_for_drain();

      // First random batch, with the long receiver hold-off part way in.
      repeat (70) report_queue.push_back(random_report());
      while (report_queue.size() > 50) @(negedge clock);
      hold_armed = 1'b1;
      wait_for_drain();

      // Second random batch, with a stretch of no idling on either side.
      repeat (75) report_queue.push_back(random_report());
      while (report_queue.size() > 60) @(negedge clock);
      steady = 1'b1;
      while (report_queue.size() > 20) @(negedge clock);
      steady = 1'b0;
      wait_for_drain();

      // Let any stray event show up before the verdict.
      repeat (40) @(negedge clock);
      $display("Sent %0d reports (%0d short and dropped); checked %0d key events,",
               reports_taken, short_reports, events_seen);
      $display("%0d presses and %0d releases, with %0d mismatches.",
               presses_seen, releases_seen, mismatches);
      if (mismatches == 0 && key_events.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
